// ===== rtl/utf8_width_line_fitter_core_macros.svh =====
// assertion macros for the utf8 width line fitter
`ifndef UTF8_WIDTH_LINE_FITTER_CORE_MACROS_SVH
`define UTF8_WIDTH_LINE_FITTER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define UWLF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uwlf same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define UWLF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uwlf next-cycle check failed");

`endif

// ===== rtl/uwlf_pkg.sv =====
// shared types, constants and width functions of the utf8 width line fitter
package uwlf_pkg;

  localparam logic [15:0] REPL_CHAR      = 16'hFFFF;
  localparam logic [15:0] LINE_WIDTH_RST = 16'd128;
  localparam logic [15:0] LAM_CHAR       = 16'h0644;
  localparam int          Q_DEPTH        = 4;

  // one result item
  typedef struct packed {
    logic [15:0] code;
    logic [1:0]  cells;
    logic        comb;
    logic        bad;
    logic [15:0] px;
    logic        over;
    logic        eot;
  } res_t;

  // decoder state
  typedef struct packed {
    logic [20:0] partial;
    logic [1:0]  left;
    logic [15:0] prev;
    logic [15:0] sum;
  } st_t;

  // outcome of handling a byte as a lead
  typedef struct packed {
    logic hit;
    res_t res;
    st_t  st;
  } lead_t;

  // combining marks: thai and arabic ranges, alef forms after lam
  function automatic logic combines(logic [15:0] prev, logic [15:0] code);
    logic r;
    r = (code inside {[16'h0610:16'h0615], [16'h064B:16'h065E], [16'h06D6:16'h06ED],
                      16'h0E31, [16'h0E34:16'h0E3A], [16'h0E47:16'h0E4E]});
    if (prev == LAM_CHAR && code inside {[16'h0622:16'h0627]}) begin
      r = 1'b1;
    end
    return r;
  endfunction

  // one character: cell width and saturating pixel sum
  function automatic res_t emit(logic [15:0] prev, logic [15:0] sum, logic [15:0] lw,
                                logic [15:0] code, logic bad);
    res_t        r;
    logic [16:0] s;
    r.code = code;
    r.bad  = bad;
    r.eot  = 1'b0;
    r.comb = combines(prev, code);
    if (r.comb) begin
      r.cells = 2'd0;
    end else if (code >= 16'h3000 && code < 16'hFB00) begin
      r.cells = 2'd2;
    end else begin
      r.cells = 2'd1;
    end
    s    = {1'b0, sum} + {12'b0, r.cells, 3'b000};
    r.px = s[16] ? 16'hFFFF : s[15:0];
    r.over = (r.px > lw);
    return r;
  endfunction

  // result of the terminating nul
  function automatic res_t end_res(logic [15:0] sum, logic [15:0] lw);
    res_t r;
    r       = '0;
    r.px    = sum;
    r.over  = (sum > lw);
    r.eot   = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/utf8_width_line_fitter_core.sv =====
// top level of the utf8 to ucs2 decoder with display width tracking
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   input    | in_valid / in_stall    | text_byte
//   output   | out_valid / out_stall  | code_point .. end_of_text
//   config   | cfg_valid / cfg_ready  | line_width_px
//
// one byte per cycle while in_stall is low; a byte moves from the input
// register into the result queue and leaves from its head. a byte that breaks
// a sequence may give two results, which leave over two output transfers.
// input stalls while a byte waits in the input register and the queue has
// fewer than two free entries. synchronous reset clears decoder state and
// queue, and sets the line budget to 128. cfg_ready is always high.
module utf8_width_line_fitter_core #(
  parameter int QDEPTH = uwlf_pkg::Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_point,
  output logic [1:0]  cell_width,
  output logic        is_combining,
  output logic        is_malformed,
  output logic [15:0] running_px,
  output logic        over_width,
  output logic        end_of_text,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] line_width_px
);
  import uwlf_pkg::*;

  logic        ib_valid;
  logic [7:0]  ib_byte;
  logic [15:0] lw;
  logic        room2;
  logic        advance;
  logic [1:0]  dec_cnt;
  logic [1:0]  push_cnt;
  res_t        res0;
  res_t        res1;
  res_t        head;

  assign cfg_ready = 1'b1;
  assign advance   = ib_valid && room2;
  assign in_stall  = ib_valid && !room2;
  assign push_cnt  = advance ? dec_cnt : 2'd0;

  // line budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      lw <= LINE_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      lw <= line_width_px;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (!in_stall) begin
      ib_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib_byte <= text_byte;
    end
  end

  uwlf_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .byte_in  (ib_byte),
    .lw       (lw),
    .push_cnt (dec_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  uwlf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .d0        (res0),
    .d1        (res1),
    .pop       (out_valid && !out_stall),
    .room2     (room2),
    .not_empty (out_valid),
    .q         (head)
  );

  // result fields
  assign code_point   = head.code;
  assign cell_width   = head.cells;
  assign is_combining = head.comb;
  assign is_malformed = head.bad;
  assign running_px   = head.px;
  assign over_width   = head.over;
  assign end_of_text  = head.eot;

  `include "utf8_width_line_fitter_core_macros.svh"

  `UWLF_ASSERT_IMP(a_eot_clean, out_valid && end_of_text, code_point == 16'h0000 && cell_width == 2'd0 && !is_combining && !is_malformed)
  `UWLF_ASSERT_IMP(a_comb_zero, out_valid && is_combining, cell_width == 2'd0)
  `UWLF_ASSERT_IMP(a_bad_repl, out_valid && is_malformed, code_point == REPL_CHAR)
  `UWLF_ASSERT_NXT(a_in_taken, in_valid && !in_stall, ib_valid)

endmodule

// ===== rtl/uwlf_decode.sv =====
// utf8 decoder state and per-byte result logic, up to two results per byte
module uwlf_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [7:0]         byte_in,
  input  logic [15:0]        lw,
  output logic [1:0]         push_cnt,
  output uwlf_pkg::res_t     res0,
  output uwlf_pkg::res_t     res1
);
  import uwlf_pkg::*;

  st_t st;
  st_t st_next;

  // handle a byte as the start of a character
  function automatic lead_t lead_byte(st_t s, logic [7:0] c, logic [15:0] l);
    lead_t o;
    o.hit = 1'b1;
    o.st  = s;
    o.res = '0;
    if (c == 8'h00) begin
      o.res = end_res(s.sum, l);
      o.st  = '0;
    end else if (c < 8'h80) begin
      o.res     = emit(s.prev, s.sum, l, {8'h00, c}, 1'b0);
      o.st.prev = {8'h00, c};
      o.st.sum  = o.res.px;
    end else if (c < 8'hC2 || c >= 8'hF5) begin
      o.res     = emit(s.prev, s.sum, l, REPL_CHAR, 1'b1);
      o.st.prev = REPL_CHAR;
      o.st.sum  = o.res.px;
    end else begin
      o.hit = 1'b0;
      if (c < 8'hE0) begin
        o.st.partial = {16'b0, c[4:0]};
        o.st.left    = 2'd1;
      end else if (c < 8'hF0) begin
        o.st.partial = {17'b0, c[3:0]};
        o.st.left    = 2'd2;
      end else begin
        o.st.partial = {18'b0, c[2:0]};
        o.st.left    = 2'd3;
      end
    end
    return o;
  endfunction

  // next state and results for the byte in the input register
  always_comb begin
    lead_t       l;
    st_t         mid;
    logic [20:0] pc;
    logic [1:0]  left_n;
    l        = '0;
    mid      = st;
    pc       = {st.partial[14:0], byte_in[5:0]};
    left_n   = st.left - 2'd1;
    st_next  = st;
    res0     = '0;
    res1     = '0;
    push_cnt = 2'd0;
    if (st.left == 2'd0) begin
      l        = lead_byte(st, byte_in, lw);
      res0     = l.res;
      st_next  = l.st;
      push_cnt = {1'b0, l.hit};
    end else if (byte_in[7:6] == 2'b10) begin
      if (left_n == 2'd0) begin
        if (pc == 21'd0) begin
          res0 = emit(st.prev, st.sum, lw, REPL_CHAR, 1'b1);
        end else if (pc[20:16] != 5'd0) begin
          res0 = emit(st.prev, st.sum, lw, REPL_CHAR, 1'b0);
        end else begin
          res0 = emit(st.prev, st.sum, lw, pc[15:0], 1'b0);
        end
        st_next.partial = '0;
        st_next.left    = 2'd0;
        st_next.prev    = res0.code;
        st_next.sum     = res0.px;
        push_cnt        = 2'd1;
      end else begin
        st_next.partial = pc;
        st_next.left    = left_n;
      end
    end else begin
      // broken sequence: replacement, then the byte again as a lead
      res0        = emit(st.prev, st.sum, lw, REPL_CHAR, 1'b1);
      mid.partial = '0;
      mid.left    = 2'd0;
      mid.prev    = REPL_CHAR;
      mid.sum     = res0.px;
      l           = lead_byte(mid, byte_in, lw);
      res1        = l.res;
      st_next     = l.st;
      push_cnt    = l.hit ? 2'd2 : 2'd1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

// ===== rtl/uwlf_queue.sv =====
// result queue taking up to two results per cycle, one out per transfer
module uwlf_queue #(
  parameter int DEPTH = uwlf_pkg::Q_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     push_cnt,
  input  uwlf_pkg::res_t d0,
  input  uwlf_pkg::res_t d1,
  input  logic           pop,
  output logic           room2,
  output logic           not_empty,
  output uwlf_pkg::res_t q
);
  import uwlf_pkg::*;

  // depth must be a power of two so the pointers wrap on their own; the block does not enforce it
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;

  assign room2     = (count <= CW'(DEPTH - 2));
  assign not_empty = (count != '0);
  assign q         = mem[rp];

  // storage writes
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wp] <= d0;
    end
    if (push_cnt == 2'd2) begin
      mem[wp + PW'(1)] <= d1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push_cnt);
      rp    <= rp + PW'(pop);
      count <= count + CW'(push_cnt) - CW'(pop);
    end
  end

endmodule
